FILE: sv/framed_uart_receiver_with_ack_core_macros.svh
// Assertion macros shared by the receiver core.
`ifndef FRAMED_UART_RECEIVER_WITH_ACK_CORE_MACROS_SVH
`define FRAMED_UART_RECEIVER_WITH_ACK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FRX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FRX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/frx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frx_pkg;

  localparam int BUF_DEPTH = 64;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int IDX_W     = 6;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  localparam logic [IDX_W-1:0] DRAIN_TOP = IDX_W'(62);

  localparam logic [2:0] CFG_START   = 3'd0;
  localparam logic [2:0] CFG_END     = 3'd1;
  localparam logic [2:0] CFG_POS_ACK = 3'd2;
  localparam logic [2:0] CFG_NEG_ACK = 3'd3;
  localparam logic [2:0] CFG_MAX_LEN = 3'd4;

  localparam logic [1:0] KIND_ACK_MATCHED = 2'd0;
  localparam logic [1:0] KIND_SEND_POS    = 2'd1;
  localparam logic [1:0] KIND_SEND_NEG    = 2'd2;
  localparam logic [1:0] KIND_FRAME_BYTE  = 2'd3;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_DATA  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] awaited_seq;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0]       start_byte;
    logic [7:0]       end_byte;
    logic [7:0]       pos_ack_type;
    logic [7:0]       neg_ack_type;
    logic [IDX_W-1:0] max_frame_len;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]       op;
    logic             ovf;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [7:0]       awaited;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: sv/frx_front.sv
`timescale 1ns / 1ps
`default_nettype none

module frx_front import frx_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  input  cfg_regs_t  cfg,
  input  q_stat_t    q_stat,
  output logic       push,
  output cmd_t       cmd
);

  logic [IDX_W-1:0] wr_idx_r;
  logic [IDX_W-1:0] wr_idx_nxt;
  logic [IDX_W:0]   next_idx;
  logic             ovf;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign next_idx = {1'b0, wr_idx_r} + (IDX_W + 1)'(1);
  assign ovf      = next_idx > {1'b0, cfg.max_frame_len};

  always_comb begin
    cmd.idx     = wr_idx_r;
    cmd.data    = in_word.rx_byte;
    cmd.awaited = in_word.awaited_seq;
    cmd.ovf     = 1'b0;
    if (in_word.rx_byte == cfg.start_byte) begin
      cmd.op     = CMD_START;
      wr_idx_nxt = IDX_W'(1);
    end else if (in_word.rx_byte == cfg.end_byte) begin
      cmd.op     = CMD_END;
      wr_idx_nxt = '0;
    end else begin
      cmd.op     = CMD_DATA;
      cmd.ovf    = ovf;
      wr_idx_nxt = ovf ? '0 : next_idx[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
    end else if (push) begin
      wr_idx_r <= wr_idx_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/frx_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module frx_cmd_fifo import frx_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      push,
  input  cmd_t     cmd_in,
  input  wire      pop,
  output cmd_t     cmd_out,
  output q_stat_t  stat
);

  cmd_t            q_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;

  assign cmd_out    = q_mem[rd_ptr_r];
  assign stat.full  = cnt_r == Q_CW'(Q_DEPTH);
  assign stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/frx_back.sv
`timescale 1ns / 1ps
`default_nettype none

module frx_back import frx_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  cfg_regs_t  cfg,
  input  q_stat_t    q_stat,
  input  cmd_t       cmd_in,
  output logic       pop,
  output logic       busy,
  output logic       out_valid,
  input  wire        out_ready,
  output out_word_t  out_word
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_RD_SEQ  = 4'd2;
  localparam logic [3:0] S_RD_TYPE = 4'd3;
  localparam logic [3:0] S_DECIDE  = 4'd4;
  localparam logic [3:0] S_NEG     = 4'd5;
  localparam logic [3:0] S_DR_RD   = 4'd6;
  localparam logic [3:0] S_DR_OUT  = 4'd7;

  localparam logic [BUF_DEPTH-1:0] ONE_HOT0 = BUF_DEPTH'(1);

  logic [3:0]           state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [7:0]           seq_r, seq_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [IDX_W-1:0]     top_r, top_nxt;
  logic [BUF_DEPTH-1:0] valid_r, valid_nxt;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic [7:0]           store_mem [BUF_DEPTH];
  logic [7:0]           rd_data_r;
  logic                 rd_vld_r;
  logic [7:0]           rd_byte;

  logic                 we, re, clr_all, clr0, load, slot_free;
  logic [BUF_AW-1:0]    waddr, raddr;
  logic [7:0]           wdata;
  out_word_t            load_word;

  assign rd_byte   = rd_vld_r ? rd_data_r : 8'd0;
  assign slot_free = !out_valid_r || out_ready;
  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    seq_nxt   = seq_r;
    cnt_nxt   = cnt_r;
    top_nxt   = top_r;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = BUF_AW'(cmd_r.idx);
    wdata     = cmd_r.data;
    re        = 1'b0;
    raddr     = BUF_AW'(cnt_r);
    clr_all   = 1'b0;
    clr0      = 1'b0;
    load      = 1'b0;
    load_word = '{kind: KIND_FRAME_BYTE, value: rd_byte, last: cnt_r == top_r};
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cmd_nxt   = cmd_in;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        we = 1'b1;
        if (cmd_r.op == CMD_START) begin
          clr_all   = 1'b1;
          waddr     = '0;
          state_nxt = S_IDLE;
        end else if (cmd_r.op == CMD_END || cmd_r.ovf) begin
          state_nxt = S_RD_SEQ;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_SEQ: begin
        re        = 1'b1;
        raddr     = BUF_AW'(1);
        state_nxt = (cmd_r.op == CMD_END) ? S_RD_TYPE : S_NEG;
      end
      S_RD_TYPE: begin
        re        = 1'b1;
        raddr     = BUF_AW'(2);
        seq_nxt   = rd_byte;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (rd_byte == cfg.pos_ack_type) begin
          if (seq_r != cmd_r.awaited) begin
            clr0      = 1'b1;
            state_nxt = S_IDLE;
          end else if (slot_free) begin
            load      = 1'b1;
            load_word = '{kind: KIND_ACK_MATCHED, value: seq_r, last: 1'b1};
            clr0      = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (rd_byte == cfg.neg_ack_type) begin
          clr0      = 1'b1;
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          load      = 1'b1;
          load_word = '{kind: KIND_SEND_POS, value: seq_r, last: 1'b0};
          cnt_nxt   = '0;
          top_nxt   = (cmd_r.idx > DRAIN_TOP) ? DRAIN_TOP : cmd_r.idx;
          state_nxt = S_DR_RD;
        end
      end
      S_NEG: begin
        if (slot_free) begin
          load      = 1'b1;
          load_word = '{kind: KIND_SEND_NEG, value: rd_byte, last: 1'b1};
          clr0      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DR_RD: begin
        re        = 1'b1;
        state_nxt = S_DR_OUT;
      end
      S_DR_OUT: begin
        if (slot_free) begin
          load = 1'b1;
          if (cnt_r == top_r) begin
            state_nxt = S_IDLE;
          end else begin
            cnt_nxt   = cnt_r + IDX_W'(1);
            state_nxt = S_DR_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (clr_all) begin
      valid_nxt = '0;
    end
    if (we) begin
      valid_nxt = valid_nxt | (ONE_HOT0 << waddr);
    end
    if (clr0) begin
      valid_nxt[0] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= store_mem[raddr];
      rd_vld_r  <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    seq_r <= seq_nxt;
    cnt_r <= cnt_nxt;
    top_r <= top_nxt;
    if (load) begin
      out_word_r <= load_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/framed_uart_receiver_with_ack_core.sv
// A byte enters the queue, is popped into the command register while the store engine is idle
// and is stored in S_EXEC. A closing byte then passes S_RD_SEQ, S_RD_TYPE and S_DECIDE, an
// overlong one S_RD_SEQ and S_NEG, before out_valid can rise. Bytes enter every cycle until the
// 2-word queue fills; the engine takes no new byte until idle and waits on out_ready to load.
// Reset (synchronous, active low) restores register defaults, clears the index, the queue
// and the entry valid bits at once, so the whole store reads as zero.
`timescale 1ns / 1ps
`default_nettype none

module framed_uart_receiver_with_ack_core import frx_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  wire        out_ready,
  output out_word_t  out_word,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [7:0]  cfg_data
);

  cfg_regs_t cfg_r;
  q_stat_t   q_stat;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;
  logic      bk_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= 8'd60;
      cfg_r.end_byte      <= 8'd62;
      cfg_r.pos_ack_type  <= 8'd6;
      cfg_r.neg_ack_type  <= 8'd21;
      cfg_r.max_frame_len <= IDX_W'(50);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START:   cfg_r.start_byte    <= cfg_data;
        CFG_END:     cfg_r.end_byte      <= cfg_data;
        CFG_POS_ACK: cfg_r.pos_ack_type  <= cfg_data;
        CFG_NEG_ACK: cfg_r.neg_ack_type  <= cfg_data;
        CFG_MAX_LEN: cfg_r.max_frame_len <= cfg_data[IDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  frx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .cfg      (cfg_r),
    .q_stat   (q_stat),
    .push     (push),
    .cmd      (push_cmd)
  );

  frx_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .cmd_in  (push_cmd),
    .pop     (pop),
    .cmd_out (head_cmd),
    .stat    (q_stat)
  );

  frx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .cmd_in    (head_cmd),
    .pop       (pop),
    .busy      (bk_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

`include "framed_uart_receiver_with_ack_core_macros.svh"

  `FRX_ASSERT_NOW(a_queue_flags, 1'b1, !(q_stat.full && q_stat.empty), "queue full and empty")
  `FRX_ASSERT_NEXT(a_take_cmd, !q_stat.empty && !bk_busy, bk_busy, "queued word not taken")
  `FRX_ASSERT_NOW(a_pop_idle, pop, !bk_busy && !q_stat.empty, "pop while busy or empty")
  `FRX_ASSERT_NOW(a_ack_last, out_valid && out_word.kind == KIND_ACK_MATCHED,
                  out_word.last, "ack match not marked last")

endmodule

`default_nettype wire
